// File: rtl/core/sdps_pkg.sv
// shared constants for the sphere diffuse pixel shader core
package sdps_pkg;

  localparam int IMAGE_WIDTH_DEF  = 512;
  localparam int IMAGE_HEIGHT_DEF = 512;

  localparam int PIX_W  = 9;
  localparam int LIGHT_W = 16;
  localparam int RAD_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int COLOR_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd3;

  localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd16384;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd0;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd11585;
  localparam logic [RAD_W-1:0]          RADIUS_RST  = 17'd32768;
  localparam logic [RAD_W-1:0]          ONE_Q16     = 17'd65536;

  localparam logic [COLOR_W-1:0] BASE_LEVEL = 8'd10;
  localparam logic [COLOR_W-1:0] GAIN       = 8'd195;
  localparam logic [COLOR_W-1:0] BG_BLUE    = 8'd221;
  localparam logic [COLOR_W-1:0] Q_MAX      = 8'd245;

  // reciprocal scaling for the pixel to coordinate map
  localparam int RECIP_SHIFT = 43;
  localparam int RECIP_W     = 44;

endpackage

// File: rtl/core/sphere_diffuse_pixel_shader_core.sv
// sphere diffuse pixel shader core: 33-stage pipeline from pixel to color
//
// input channel: in_valid / in_ready carry one pixel (column, row) per beat
// result channel: out_valid / out_ready carry one color (red, green, blue,
// on_sphere) per beat, one result beat for every input beat, in order
// config port: cfg_we with cfg_index and cfg_wdata writes light_x, light_y,
// light_z or sphere_radius in one cycle; write only while the pipeline is empty
// latency: 33 cycles from input beat to result beat with no stall
// throughput: one pixel per cycle; the 17 square root stages (one root bit
// each) and the 8 division stages (one quotient bit each) set the depth
// reset: synchronous active low rst_n empties every stage and loads the
// light and radius registers with their defaults
// stall: each stage holds while the one after it is full and stalled, so
// empty stages keep filling while a result waits; in_ready drops only when
// every stage is full and out_ready is low
module sphere_diffuse_pixel_shader_core #(
  parameter int IMAGE_WIDTH  = sdps_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = sdps_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sdps_pkg::PIX_W-1:0]            in_pixel_column,
  input  logic [sdps_pkg::PIX_W-1:0]            in_pixel_row,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sdps_pkg::COLOR_W-1:0]          out_red,
  output logic [sdps_pkg::COLOR_W-1:0]          out_green,
  output logic [sdps_pkg::COLOR_W-1:0]          out_blue,
  output logic                                  out_on_sphere,
  input  logic                                  cfg_we,
  input  logic [sdps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sdps_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int SQ_N   = 17;               // square root stages
  localparam int DV_N   = 8;                // division stages
  localparam int K_SQ0  = 3;                // first square root stage
  localparam int K_ZL   = K_SQ0 + SQ_N;     // z times light_z
  localparam int K_S    = K_ZL + 1;         // dot product
  localparam int K_N    = K_S + 1;          // scaled numerator
  localparam int K_OV   = K_N + 1;          // overflow check
  localparam int K_DV0  = K_OV + 1;         // first division stage
  localparam int K_OUT  = K_DV0 + DV_N;     // output register
  localparam int NS     = K_OUT + 1;

  // reciprocals of the image size, exact for every pixel index below the size
  localparam logic [sdps_pkg::RECIP_W-1:0] COL_RECIP = sdps_pkg::RECIP_W'(
    ((64'd1 << sdps_pkg::RECIP_SHIFT) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
  localparam logic [sdps_pkg::RECIP_W-1:0] ROW_RECIP = sdps_pkg::RECIP_W'(
    ((64'd1 << sdps_pkg::RECIP_SHIFT) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));
  localparam int PROD_W = sdps_pkg::RECIP_W + sdps_pkg::PIX_W;
  localparam int SC_LSB = sdps_pkg::RECIP_SHIFT - 17;

  // configuration registers
  logic signed [15:0] light_x_r, light_y_r, light_z_r;
  logic [16:0]        radius_r;
  logic [16:0]        rad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= sdps_pkg::LIGHT_X_RST;
      light_y_r <= sdps_pkg::LIGHT_Y_RST;
      light_z_r <= sdps_pkg::LIGHT_Z_RST;
      radius_r  <= sdps_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdps_pkg::REG_LIGHT_X: light_x_r <= cfg_wdata[15:0];
        sdps_pkg::REG_LIGHT_Y: light_y_r <= cfg_wdata[15:0];
        sdps_pkg::REG_LIGHT_Z: light_z_r <= cfg_wdata[15:0];
        sdps_pkg::REG_RADIUS:  radius_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // radius saturated at one
  assign rad = (radius_r > sdps_pkg::ONE_Q16) ? sdps_pkg::ONE_Q16 : radius_r;

  // stage valid bits and per-stage advance
  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // stage 0: reciprocal products
  logic [PROD_W-1:0] pu_r, pv_r;
  logic              inimg_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pu_r    <= PROD_W'(in_pixel_column) * PROD_W'(COL_RECIP);
      pv_r    <= PROD_W'(in_pixel_row) * PROD_W'(ROW_RECIP);
      inimg_r <= (32'(in_pixel_column) < IMAGE_WIDTH) && (32'(in_pixel_row) < IMAGE_HEIGHT);
    end
  end

  // stage 1: u, v, their squares and the square of the radius
  logic signed [17:0] u1, v1;
  logic signed [17:0] u_r, v_r2;
  logic [32:0]        uu_r, vv_r, rr_r;
  logic               hpre_r;

  assign u1 = $signed({1'b0, pu_r[SC_LSB+16:SC_LSB]}) - 18'sd65536;
  assign v1 = $signed({1'b0, pv_r[SC_LSB+16:SC_LSB]}) - 18'sd65536;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u_r    <= u1;
      v_r2   <= v1;
      uu_r   <= 33'(36'(u1 * u1));
      vv_r   <= 33'(36'(v1 * v1));
      rr_r   <= 33'(rad) * 33'(rad);
      hpre_r <= inimg_r && (rad != 17'd0);
    end
  end

  // stage 2: disc test, radicand, light x and y terms
  logic [33:0]        r2;
  logic               hit2_r;
  logic [33:0]        rcnd_r;
  logic signed [33:0] xu_r, yv_r;

  assign r2 = 34'(uu_r) + 34'(vv_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hit2_r <= hpre_r && (r2 <= 34'(rr_r));
      rcnd_r <= 34'(rr_r) - r2;
      xu_r   <= light_x_r * u_r;
      yv_r   <= light_y_r * v_r2;
    end
  end

  // square root stages, one root bit each
  logic [33:0]        sq_rad_r  [SQ_N];
  logic [16:0]        sq_root_r [SQ_N];
  logic [17:0]        sq_rem_r  [SQ_N];
  logic               sq_hit_r  [SQ_N];
  logic signed [34:0] sq_xy_r   [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    logic [33:0]        rad_in;
    logic [16:0]        root_in;
    logic [17:0]        rem_in;
    logic               hit_in;
    logic signed [34:0] xy_in;
    logic [19:0]        cur, trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign rad_in  = rcnd_r;
      assign root_in = '0;
      assign rem_in  = '0;
      assign hit_in  = hit2_r;
      assign xy_in   = 35'(xu_r) + 35'(yv_r);
    end else begin : g_next
      assign rad_in  = sq_rad_r[i-1];
      assign root_in = sq_root_r[i-1];
      assign rem_in  = sq_rem_r[i-1];
      assign hit_in  = sq_hit_r[i-1];
      assign xy_in   = sq_xy_r[i-1];
    end

    assign cur   = {rem_in, rad_in[33:32]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en[K_SQ0+i]) begin
        sq_rad_r[i]  <= {rad_in[31:0], 2'b00};
        sq_root_r[i] <= {root_in[15:0], ge};
        sq_rem_r[i]  <= ge ? 18'(cur - trial) : 18'(cur);
        sq_hit_r[i]  <= hit_in;
        sq_xy_r[i]   <= xy_in;
      end
    end
  end

  // z term
  logic signed [33:0] zl_r;
  logic signed [34:0] xyz_r;
  logic               hitz_r;

  always_ff @(posedge clk) begin
    if (en[K_ZL]) begin
      zl_r   <= light_z_r * $signed({1'b0, sq_root_r[SQ_N-1]});
      xyz_r  <= sq_xy_r[SQ_N-1];
      hitz_r <= sq_hit_r[SQ_N-1];
    end
  end

  // dot product
  logic signed [35:0] s_r;
  logic               hits_r;

  always_ff @(posedge clk) begin
    if (en[K_S]) begin
      s_r    <= 36'(xyz_r) + 36'(zl_r);
      hits_r <= hitz_r;
    end
  end

  // numerator 195 * s over 2^14 for positive s
  logic [43:0] num;
  logic [28:0] n_r;
  logic        pos_r, hitn_r;

  assign num = 44'(s_r[34:0]) * 44'(sdps_pkg::GAIN);

  always_ff @(posedge clk) begin
    if (en[K_N]) begin
      n_r    <= num[42:14];
      pos_r  <= (s_r > 36'sd0);
      hitn_r <= hits_r;
    end
  end

  // quotient at or above 256 saturates
  logic [28:0] no_r;
  logic        ovf_r, poso_r, hito_r;

  always_ff @(posedge clk) begin
    if (en[K_OV]) begin
      no_r   <= n_r;
      ovf_r  <= n_r >= 29'({rad, 8'd0});
      poso_r <= pos_r;
      hito_r <= hitn_r;
    end
  end

  // restoring division stages, one quotient bit each
  logic [28:0] dv_n_r   [DV_N];
  logic [7:0]  dv_q_r   [DV_N];
  logic        dv_ovf_r [DV_N];
  logic        dv_pos_r [DV_N];
  logic        dv_hit_r [DV_N];

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [28:0] n_in, d_sh;
    logic [7:0]  q_in;
    logic        ovf_in, pos_in, hit_in;
    logic        ge;

    if (j == 0) begin : g_first
      assign n_in   = no_r;
      assign q_in   = '0;
      assign ovf_in = ovf_r;
      assign pos_in = poso_r;
      assign hit_in = hito_r;
    end else begin : g_next
      assign n_in   = dv_n_r[j-1];
      assign q_in   = dv_q_r[j-1];
      assign ovf_in = dv_ovf_r[j-1];
      assign pos_in = dv_pos_r[j-1];
      assign hit_in = dv_hit_r[j-1];
    end

    assign d_sh = 29'(rad) << (DV_N - 1 - j);
    assign ge   = n_in >= d_sh;

    always_ff @(posedge clk) begin
      if (en[K_DV0+j]) begin
        dv_n_r[j]   <= ge ? n_in - d_sh : n_in;
        dv_q_r[j]   <= {q_in[6:0], ge};
        dv_ovf_r[j] <= ovf_in;
        dv_pos_r[j] <= pos_in;
        dv_hit_r[j] <= hit_in;
      end
    end
  end

  // color output register
  logic [7:0] q_fin, level;
  logic [7:0] red_r, green_r, blue_r;
  logic       on_r;

  always_comb begin
    priority if (dv_ovf_r[DV_N-1] || dv_q_r[DV_N-1] > sdps_pkg::Q_MAX) begin
      q_fin = sdps_pkg::Q_MAX;
    end else begin
      q_fin = dv_q_r[DV_N-1];
    end
    level = dv_pos_r[DV_N-1] ? sdps_pkg::BASE_LEVEL + q_fin : sdps_pkg::BASE_LEVEL;
  end

  always_ff @(posedge clk) begin
    if (en[K_OUT]) begin
      if (dv_hit_r[DV_N-1]) begin
        red_r   <= level;
        green_r <= level;
        blue_r  <= 8'd0;
        on_r    <= 1'b1;
      end else begin
        red_r   <= sdps_pkg::BASE_LEVEL;
        green_r <= sdps_pkg::BASE_LEVEL;
        blue_r  <= sdps_pkg::BG_BLUE;
        on_r    <= 1'b0;
      end
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_on_sphere = on_r;

endmodule

// File: tb/sv/tb_sphere_diffuse_pixel_shader_core.sv
// testbench for the sphere diffuse pixel shader core: directed table, random pixels, color predictor
`timescale 1ns / 100ps

module tb_sphere_diffuse_pixel_shader_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;   // a bit over the 33-stage pipeline

  typedef logic [sdps_pkg::PIX_W-1:0]      pix_t;
  typedef logic [sdps_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic [sdps_pkg::COLOR_W-1:0] red;
    logic [sdps_pkg::COLOR_W-1:0] green;
    logic [sdps_pkg::COLOR_W-1:0] blue;
    logic                         on_sphere;
  } color_t;

  typedef struct {
    pix_t   col;
    pix_t   row;
    bit     typed;   // expected color given in the row
    color_t color;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_pixel_column = '0;
  pix_t in_pixel_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [sdps_pkg::COLOR_W-1:0] out_red, out_green, out_blue;
  logic out_on_sphere;
  logic cfg_we = 1'b0;
  logic [sdps_pkg::CFG_IDX_W-1:0] cfg_index = sdps_pkg::REG_LIGHT_X;
  cfg_data_t cfg_wdata = '0;

  sphere_diffuse_pixel_shader_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the light and radius registers
  logic signed [sdps_pkg::LIGHT_W-1:0] lx = sdps_pkg::LIGHT_X_RST;
  logic signed [sdps_pkg::LIGHT_W-1:0] ly = sdps_pkg::LIGHT_Y_RST;
  logic signed [sdps_pkg::LIGHT_W-1:0] lz = sdps_pkg::LIGHT_Z_RST;
  logic [sdps_pkg::RAD_W-1:0] radius = sdps_pkg::RADIUS_RST;

  color_t pending_colors[$];
  color_t typed_colors[$];   // typed-in colors, checked against the predictor on accept
  bit     typed_flags[$];
  int     error_count = 0;
  int     cycle_count = 0;
  bit     quiet = 1'b0;      // no idling on either side
  bit     long_hold = 1'b0;  // receiver holds off for a long stretch

  // integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic color_t shade_pixel(pix_t col, pix_t row);
    longint rad, u, v, z, s, q, r2, rr;
    color_t c;
    rad = (radius > sdps_pkg::ONE_Q16) ? 65536 : longint'(radius);
    c = '{red: sdps_pkg::BASE_LEVEL, green: sdps_pkg::BASE_LEVEL, blue: sdps_pkg::BG_BLUE,
          on_sphere: 1'b0};
    if (col >= sdps_pkg::IMAGE_WIDTH_DEF || row >= sdps_pkg::IMAGE_HEIGHT_DEF || rad == 0)
      return c;
    u = (2 * longint'(col) * 65536) / sdps_pkg::IMAGE_WIDTH_DEF - 65536;
    v = (2 * longint'(row) * 65536) / sdps_pkg::IMAGE_HEIGHT_DEF - 65536;
    r2 = u * u + v * v;
    rr = rad * rad;
    if (r2 > rr) return c;
    z = longint'(isqrt(rr - r2));
    s = longint'(lx) * u + longint'(ly) * v + longint'(lz) * z;
    q = 0;
    if (s > 0) begin
      q = (s * 195) / (rad << 14);
      if (q > longint'(sdps_pkg::Q_MAX)) q = longint'(sdps_pkg::Q_MAX);
    end
    c.red = sdps_pkg::BASE_LEVEL + q[7:0];
    c.green = c.red;
    c.blue = '0;
    c.on_sphere = 1'b1;
    return c;
  endfunction

  // accept and check at the rising edge
  always @(posedge clk) begin
    color_t got, want, pred;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sphere_diffuse_pixel_shader_core: errors");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      pred = shade_pixel(in_pixel_column, in_pixel_row);
      if (typed_flags.size() != 0 && typed_flags.pop_front()) begin
        want = typed_colors.pop_front();
        if (want != pred) begin
          $error("typed color %h differs from predicted %h", want, pred);
          error_count++;
        end
      end
      pending_colors.insert(pending_colors.size(), pred);
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_red, out_green, out_blue, out_on_sphere};
      if (pending_colors.size() == 0) begin
        $error("result beat with no pixel outstanding");
        error_count++;
      end else begin
        want = pending_colors.pop_front();
        if (got.red != want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red); error_count++;
        end
        if (got.green != want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green); error_count++;
        end
        if (got.blue != want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue); error_count++;
        end
        if (got.on_sphere != want.on_sphere) begin
          $error("on_sphere: expected %0d, got %0d", want.on_sphere, got.on_sphere);
          error_count++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // offer one pixel beat; valid then stays high until a random idle or the caller drops it
  task automatic send_pixel(pix_t col, pix_t row);
    in_valid = 1'b1;
    in_pixel_column = col;
    in_pixel_row = row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // drain the pipeline, then write one register
  task automatic write_reg(logic [sdps_pkg::CFG_IDX_W-1:0] idx, cfg_data_t data);
    in_valid = 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      sdps_pkg::REG_LIGHT_X: lx = data[sdps_pkg::LIGHT_W-1:0];
      sdps_pkg::REG_LIGHT_Y: ly = data[sdps_pkg::LIGHT_W-1:0];
      sdps_pkg::REG_LIGHT_Z: lz = data[sdps_pkg::LIGHT_W-1:0];
      default:               radius = data;
    endcase
  endtask

  task automatic send_random(int count);
    int span;
    pix_t c, r;
    span = (radius > sdps_pkg::ONE_Q16 ? 65536 : int'(radius)) >> 8;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        c = pix_t'($urandom);
        r = pix_t'($urandom);
      end else begin
        // aim inside the bounding box of the disc
        c = pix_t'(256 - span + int'($urandom_range(0, 2 * span)));
        r = pix_t'(256 - span + int'($urandom_range(0, 2 * span)));
      end
      send_pixel(c, r);
    end
  endtask

  pixel_row_t directed[] = '{
    '{9'd0,   9'd0,   1'b1, '{8'd10, 8'd10, 8'd221, 1'b0}},  // corner, off the disc
    '{9'd256, 9'd256, 1'b1, '{8'd147, 8'd147, 8'd0, 1'b1}},  // center at reset light
    '{9'd511, 9'd511, 1'b1, '{8'd10, 8'd10, 8'd221, 1'b0}},
    '{9'd0,   9'd511, 1'b1, '{8'd10, 8'd10, 8'd221, 1'b0}},
    '{9'd511, 9'd0,   1'b1, '{8'd10, 8'd10, 8'd221, 1'b0}},
    '{9'd384, 9'd256, 1'b0, '0},   // right rim
    '{9'd128, 9'd256, 1'b0, '0},   // left rim, light faces away
    '{9'd256, 9'd128, 1'b0, '0},
    '{9'd256, 9'd384, 1'b0, '0},
    '{9'd385, 9'd256, 1'b0, '0},   // just outside
    '{9'd300, 9'd200, 1'b0, '0},
    '{9'd170, 9'd341, 1'b0, '0}
  };

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      typed_flags.insert(typed_flags.size(), directed[i].typed);
      if (directed[i].typed) begin
        typed_colors.insert(typed_colors.size(), directed[i].color);
      end
      send_pixel(directed[i].col, directed[i].row);
    end

    // bright light at full radius saturates at the center
    write_reg(sdps_pkg::REG_RADIUS, 17'd65536);
    write_reg(sdps_pkg::REG_LIGHT_X, 17'h07fff);
    write_reg(sdps_pkg::REG_LIGHT_Y, 17'h18000);   // bit 16 is dropped
    write_reg(sdps_pkg::REG_LIGHT_Z, 17'h07fff);
    typed_flags.insert(typed_flags.size(), 1'b1);
    typed_colors.insert(typed_colors.size(), '{8'd255, 8'd255, 8'd0, 1'b1});
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd256);
    send_pixel(9'd256, 9'd0);
    send_random(150);

    // long receiver hold-off while pixels keep coming
    long_hold = 1'b1;
    send_random(150);

    // zero radius: background everywhere
    write_reg(sdps_pkg::REG_RADIUS, 17'd0);
    send_pixel(9'd256, 9'd256);
    send_random(60);

    // radius above one saturates
    write_reg(sdps_pkg::REG_RADIUS, 17'h1ffff);
    send_random(150);

    // light facing away
    write_reg(sdps_pkg::REG_LIGHT_X, 17'h08000);
    write_reg(sdps_pkg::REG_LIGHT_Y, 17'h08000);
    write_reg(sdps_pkg::REG_LIGHT_Z, 17'h08000);
    write_reg(sdps_pkg::REG_RADIUS, 17'd1);
    send_pixel(9'd256, 9'd256);
    write_reg(sdps_pkg::REG_RADIUS, 17'd40000);
    send_random(150);

    // random settings
    repeat (5) begin
      write_reg(sdps_pkg::REG_LIGHT_X, cfg_data_t'($urandom));
      write_reg(sdps_pkg::REG_LIGHT_Y, cfg_data_t'($urandom));
      write_reg(sdps_pkg::REG_LIGHT_Z, cfg_data_t'($urandom));
      write_reg(sdps_pkg::REG_RADIUS, cfg_data_t'($urandom_range(1, 70000)));
      send_random(120);
    end

    // last stretch with no idling on either side
    quiet = 1'b1;
    send_random(120);
    in_valid = 1'b0;

    while (pending_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_sphere_diffuse_pixel_shader_core: clean");
    end else begin
      $display("tb_sphere_diffuse_pixel_shader_core: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sdps_pkg.sv
rtl/core/sphere_diffuse_pixel_shader_core.sv
tb/sv/tb_sphere_diffuse_pixel_shader_core.sv
